// ----- rtl/ffra_pkg.sv -----
// Package: shared types, constants and helpers for the first-fit region allocator.
`timescale 1ns / 1ps
package ffra_pkg;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 32;
  localparam int MAX_REGIONS_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int CFG_W = 48;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_BYTES = 1'd1;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  size_bytes;
  } ffra_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_address;
  } ffra_out_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } ffra_ctl_t;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1; // cell 0 loads, others keep
  localparam logic [2:0] CMD_SHRINK = 3'd2; // target cell start += addr, len -= len
  localparam logic [2:0] CMD_DROP   = 3'd3; // cells at/after target take right neighbour
  localparam logic [2:0] CMD_INSERT = 3'd4; // cells after target take left, target loads
  localparam logic [2:0] CMD_WRITE  = 3'd5; // target loads addr/len

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

endpackage

// ----- rtl/ffra_cell.sv -----
// One entry of the free table: holds start and length, updated from the broadcast command.
`timescale 1ns / 1ps
module ffra_cell
  import ffra_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter logic [IDX_W-1:0] IDX = '0
) (
  input  logic              clk,
  input  ffra_ctl_t         ctl,
  input  logic [IDX_W-1:0]  target,
  input  logic [ADDR_W-1:0] left_start,
  input  logic [LEN_W-1:0]  left_len,
  input  logic [ADDR_W-1:0] right_start,
  input  logic [LEN_W-1:0]  right_len,
  output logic [ADDR_W-1:0] start,
  output logic [LEN_W-1:0]  len
);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        if (IDX == '0) begin
          start <= ctl.addr;
          len   <= ctl.len;
        end
      end
      CMD_SHRINK: begin
        if (IDX == target) begin
          start <= start + ctl.addr;
          len   <= len - ctl.len;
        end
      end
      CMD_DROP: begin
        if (IDX >= target) begin
          start <= right_start;
          len   <= right_len;
        end
      end
      CMD_INSERT: begin
        if (IDX == target) begin
          start <= ctl.addr;
          len   <= ctl.len;
        end else if (IDX > target) begin
          start <= left_start;
          len   <= left_len;
        end
      end
      CMD_WRITE: begin
        if (IDX == target) begin
          start <= ctl.addr;
          len   <= ctl.len;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/first_fit_region_allocator.sv -----
// Top level: sequencer and row of table cells for the first-fit region allocator.
//
//  channel | signals                        | handshake
//  --------+--------------------------------+----------------------------------
//  command | start, busy, cmd_in            | taken when start & !busy
//  result  | done, result                   | one-cycle strobe, cannot stall
//  config  | cfg_we, cfg_index, cfg_data    | written on any edge with cfg_we
//
// The scan reads each entry into registers and then compares it. An allocate stops at
// the first entry that fits or misses at the end of the table; a free stops at its
// insert point and then checks the entry there for a right merge, with a further drop
// step when it merges both sides. A page size that is not a power of two is rounded in
// its own state by reciprocal multiply; a power of two by shifts when the item is taken.
// rst clears the entry count and sequencer; entries need no reset. busy falls at the
// edge that raises done, so the next item may be taken as the result is taken.
`timescale 1ns / 1ps
module first_fit_region_allocator
  import ffra_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ffra_in_t             cmd_in,
  output logic                 done,
  output ffra_out_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int PG_W  = $clog2(PAGE_BYTES);
  localparam bit PG_POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;

  // reciprocal of the page size for a 33-bit dividend, split in two 17-bit halves
  localparam int RCP_K = LEN_W + 1 + PG_W;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_K) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [16:0] RCP_ML = RCP_M[16:0];
  localparam logic [16:0] RCP_MH = RCP_M[33:17];

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_DROPR = 3'd5;

  logic [ADDR_W-1:0] area_base;
  logic [LEN_W-1:0]  area_bytes;
  logic [CNT_W-1:0]  count;
  logic [2:0]        state;
  ffra_in_t          item;
  logic [LEN_W:0]    need;      // rounded size, one bit of overflow
  logic [IDX_W:0]    pos;       // scan position (may equal count)
  logic [IDX_W-1:0]  target;
  ffra_ctl_t         ctl;
  logic [1:0]        st_r;
  logic [ADDR_W-1:0] addr_r;
  logic              rnd_busy;
  logic [1:0]        rnd_step;
  logic [LEN_W:0]    rnd_t;
  logic [LEN_W+17:0] rnd_lo, rnd_hi;
  logic [LEN_W+35:0] rnd_sum;
  logic [LEN_W:0]    rnd_q;
  logic              rd_ok;     // read registers hold the entries at pos
  logic              prev_merge;

  logic [ADDR_W-1:0] cs [MAX_REGIONS];
  logic [LEN_W-1:0]  cl [MAX_REGIONS];

  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    ffra_cell #(.IDX_W(IDX_W), .IDX(IDX_W'(g))) u_cell (
      .clk(clk), .ctl(ctl), .target(target),
      .left_start (cs[(g == 0) ? 0 : g - 1]),
      .left_len   (cl[(g == 0) ? 0 : g - 1]),
      .right_start(cs[(g == MAX_REGIONS - 1) ? g : g + 1]),
      .right_len  (cl[(g == MAX_REGIONS - 1) ? g : g + 1]),
      .start(cs[g]), .len(cl[g])
    );
  end

  // current and previous entry seen by the scan
  logic [IDX_W-1:0]  pidx, qidx;
  logic [ADDR_W-1:0] cur_s, prv_s;
  logic [LEN_W-1:0]  cur_l, prv_l;
  logic              in_tab;
  logic [ADDR_W-1:0] prv_end, free_end;
  logic [LEN_W-1:0]  flen;

  assign pidx   = pos[IDX_W-1:0];
  assign qidx   = pos[IDX_W-1:0] - 1'b1;
  assign in_tab = pos < (IDX_W+1)'(count);
  assign flen   = need[LEN_W] ? {LEN_W{1'b1}} : need[LEN_W-1:0];
  assign prv_end  = prv_s + {{(ADDR_W-LEN_W){1'b0}}, prv_l};
  assign free_end = item.address + {{(ADDR_W-LEN_W){1'b0}}, flen};
  assign rnd_sum  = {rnd_hi, 17'd0} + (LEN_W+36)'(rnd_lo);

  // registered read of the entry at pos and the one before it
  always_ff @(posedge clk) begin
    cur_s <= cs[pidx];
    cur_l <= cl[pidx];
    prv_s <= cs[qidx];
    prv_l <= cl[qidx];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      area_base  <= '0;
      area_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_BASE:  area_base  <= cfg_data[ADDR_W-1:0];
        REG_AREA_BYTES: area_bytes <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      ctl.cmd <= CMD_NONE;
      rnd_busy <= 1'b0;
    end else begin
      done    <= 1'b0;
      ctl.cmd <= CMD_NONE;
      case (state)
        S_IDLE: begin
          if (start) begin
            item   <= cmd_in;
            st_r   <= ST_OK;
            addr_r <= '0;
            pos    <= '0;
            rd_ok  <= 1'b0;
            prev_merge <= 1'b0;
            if (cmd_in.op == OP_INIT) begin
              ctl.cmd  <= CMD_LOAD;
              ctl.addr <= area_base;
              ctl.len  <= area_bytes;
              count    <= CNT_W'(1);
              state    <= S_DONE;
            end else if (cmd_in.op == OP_ALLOC || cmd_in.op == OP_FREE) begin
              if (PG_POW2) begin
                need <= (({1'b0, cmd_in.size_bytes} + (LEN_W+1)'(PAGE_BYTES - 1))
                         >> PG_W) << PG_W;
                state <= S_SCAN;
              end else begin
                rnd_t    <= {1'b0, cmd_in.size_bytes} + (LEN_W+1)'(PAGE_BYTES - 1);
                rnd_step <= '0;
                rnd_busy <= 1'b1;
                state    <= S_ROUND;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ROUND: begin
          // whole pages by reciprocal multiply, then back to bytes
          case (rnd_step)
            2'd0: rnd_lo <= rnd_t * RCP_ML;
            2'd1: rnd_hi <= rnd_t * RCP_MH;
            2'd2: rnd_q  <= (LEN_W+1)'(rnd_sum >> RCP_K);
            default: begin
              need     <= rnd_q * (LEN_W+1)'(PAGE_BYTES);
              rnd_busy <= 1'b0;
              state    <= S_SCAN;
            end
          endcase
          rnd_step <= rnd_step + 1'b1;
        end
        S_SCAN: begin
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (item.op == OP_ALLOC) begin
            if (!in_tab) begin
              st_r  <= ST_NOFIT;
              state <= S_DONE;
            end else if (!need[LEN_W] && cur_l >= need[LEN_W-1:0]) begin
              addr_r <= cur_s;
              target <= pidx;
              if (cur_l == need[LEN_W-1:0]) begin
                ctl.cmd <= CMD_DROP;
                count   <= count - 1'b1;
              end else begin
                ctl.cmd  <= CMD_SHRINK;
                ctl.addr <= {{(ADDR_W-LEN_W){1'b0}}, need[LEN_W-1:0]};
                ctl.len  <= need[LEN_W-1:0];
              end
              state <= S_DONE;
            end else begin
              pos   <= pos + 1'b1;
              rd_ok <= 1'b0;
            end
          end else begin
            if (in_tab && cur_s <= item.address) begin
              pos   <= pos + 1'b1;
              rd_ok <= 1'b0;
            end else begin
              // pos is the insert point; check left merge
              if (pos != '0 && prv_end == item.address) begin
                prev_merge <= 1'b1;
                ctl.cmd  <= CMD_WRITE;
                target   <= qidx;
                ctl.addr <= prv_s;
                ctl.len  <= sat_add(prv_l, flen);
              end
              state <= S_FREE2;
            end
          end
        end
        S_FREE2: begin
          if (in_tab && cur_s == free_end) begin
            if (prev_merge) begin
              // read registers still hold the left length from before its merge
              ctl.cmd  <= CMD_WRITE;
              target   <= qidx;
              ctl.addr <= prv_s;
              ctl.len  <= sat_add(sat_add(prv_l, flen), cur_l);
              state    <= S_DROPR;
            end else begin
              ctl.cmd  <= CMD_WRITE;
              target   <= pidx;
              ctl.addr <= item.address;
              ctl.len  <= sat_add(cur_l, flen);
              state    <= S_DONE;
            end
          end else if (prev_merge) begin
            state <= S_DONE;
          end else if (count >= CNT_W'(MAX_REGIONS)) begin
            st_r  <= ST_FULL;
            state <= S_DONE;
          end else begin
            ctl.cmd  <= CMD_INSERT;
            target   <= pidx;
            ctl.addr <= item.address;
            ctl.len  <= flen;
            count    <= count + 1'b1;
            state    <= S_DONE;
          end
        end
        S_DROPR: begin
          ctl.cmd <= CMD_DROP;
          target  <= pidx;
          count   <= count - 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.status        = st_r;
  assign result.alloc_address = addr_r;

  assert property (@(posedge clk) disable iff (rst) done |-> !$past(done))
    else $error("result strobe held two cycles");
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_REGIONS))
    else $error("entry count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
                   done |-> (result.status == ST_OK || result.alloc_address == '0))
    else $error("address returned on failure");
  assert property (@(posedge clk) disable iff (rst) rnd_busy |-> state == S_ROUND)
    else $error("rounding active outside its state");

endmodule

// ----- verif/tb_first_fit_region_allocator.sv -----
// Testbench for the first-fit region allocator: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_first_fit_region_allocator;
  import ffra_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;  // unused op code, must change nothing
  localparam int PAGE = PAGE_BYTES_DEF;
  localparam int SLOTS = MAX_REGIONS_DEF;
  localparam int SETTLE_CYCLES = SLOTS + 16;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  bytes;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  ffra_in_t             cmd_in = '0;
  logic                 done;
  ffra_out_t            result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  first_fit_region_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // free table as the block should hold it
  logic [ADDR_W-1:0] free_base [SLOTS];
  logic [LEN_W-1:0]  free_len  [SLOTS];
  int                free_cnt = 0;
  logic [ADDR_W-1:0] area_base_q = '0;
  logic [LEN_W-1:0]  area_bytes_q = '0;

  ffra_out_t outcome_q [$];
  span_t     granted_q [$];
  int        fail_cnt = 0;
  bit        no_gaps = 1'b0;

  function automatic longint unsigned to_pages(input logic [LEN_W-1:0] s);
    longint unsigned p;
    p = PAGE;
    return ((longint'(s) + p - 1) / p) * p;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
  endfunction

  function automatic void remove_slot(input int i);
    for (int k = i; k + 1 < free_cnt; k++) begin
      free_base[k] = free_base[k + 1];
      free_len[k]  = free_len[k + 1];
    end
    free_cnt--;
  endfunction

  function automatic ffra_out_t predict_outcome(input ffra_in_t it);
    ffra_out_t o;
    longint unsigned need;
    logic [LEN_W-1:0] len;
    logic [ADDR_W-1:0] prev_end, next_at;
    int pos;
    bit merged, found;
    o = '0;
    case (it.op)
      OP_INIT: begin
        free_base[0] = area_base_q;
        free_len[0]  = area_bytes_q;
        free_cnt     = 1;
      end
      OP_ALLOC: begin
        need = to_pages(it.size_bytes);
        found = 1'b0;
        for (int i = 0; i < free_cnt && !found; i++) begin
          if (longint'(free_len[i]) >= need) begin
            found = 1'b1;
            o.alloc_address = free_base[i];
            if (longint'(free_len[i]) == need) begin
              remove_slot(i);
            end else begin
              free_len[i]  = free_len[i] - need[LEN_W-1:0];
              free_base[i] = free_base[i] + need[ADDR_W-1:0];
            end
          end
        end
        if (!found) o.status = ST_NOFIT;
      end
      OP_FREE: begin
        len = clamp_len(to_pages(it.size_bytes));
        pos = 0;
        merged = 1'b0;
        while (pos < free_cnt && free_base[pos] <= it.address) pos++;
        if (pos > 0) begin
          prev_end = free_base[pos - 1] + free_len[pos - 1];
          if (prev_end == it.address) begin
            free_len[pos - 1] = clamp_len(longint'(free_len[pos - 1]) + longint'(len));
            merged = 1'b1;
          end
        end
        next_at = it.address + len;
        if (pos < free_cnt && free_base[pos] == next_at) begin
          if (merged) begin
            free_len[pos - 1] =
              clamp_len(longint'(free_len[pos - 1]) + longint'(free_len[pos]));
            remove_slot(pos);
          end else begin
            free_len[pos]  = clamp_len(longint'(free_len[pos]) + longint'(len));
            free_base[pos] = it.address;
            merged = 1'b1;
          end
        end
        if (!merged) begin
          if (free_cnt >= SLOTS) begin
            o.status = ST_FULL;
          end else begin
            for (int k = free_cnt; k > pos; k--) begin
              free_base[k] = free_base[k - 1];
              free_len[k]  = free_len[k - 1];
            end
            free_base[pos] = it.address;
            free_len[pos]  = len;
            free_cnt++;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic ffra_in_t mk(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                  input logic [LEN_W-1:0] s);
    ffra_in_t it;
    it.op = op;
    it.address = a;
    it.size_bytes = s;
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(input ffra_in_t it);
    ffra_out_t want;
    start  <= 1'b1;
    cmd_in <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_outcome(it);
    outcome_q.push_back(want);
    if (it.op == OP_INIT) granted_q.delete();
    if (it.op == OP_ALLOC && want.status == ST_OK)
      granted_q.push_back('{base: want.alloc_address, bytes: it.size_bytes});
    if (!no_gaps && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // hold off until every result is back and the block has settled
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AREA_BASE) area_base_q = val[ADDR_W-1:0];
    else area_bytes_q = val[LEN_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_area(input logic [ADDR_W-1:0] b, input logic [LEN_W-1:0] n);
    wait_idle();
    write_reg(REG_AREA_BASE, b);
    write_reg(REG_AREA_BYTES, CFG_W'(n));
  endtask

  // registers still at reset: empty table, unknown op, zero-length region
  task automatic test_empty_table();
    send_item(mk(OP_ALLOC, '0, '0));
    send_item(mk(OP_NOP, '1, '1));
    send_item(mk(OP_INIT, '1, '1));
    send_item(mk(OP_ALLOC, '1, '0));
    send_item(mk(OP_ALLOC, '0, 32'd1));
  endtask

  // field extremes, wrap at the top of the address space, saturation
  task automatic test_extremes();
    set_area(48'hFFFF_FFFF_F000, 32'hFFFF_FFFF);
    send_item(mk(OP_INIT, '0, '0));
    send_item(mk(OP_ALLOC, '0, 32'hFFFF_FFFF));
    send_item(mk(OP_ALLOC, '0, 32'd1));
    send_item(mk(OP_ALLOC, '0, '0));
    send_item(mk(OP_FREE, 48'hFFFF_FFFF_F000, 32'd1));
    send_item(mk(OP_FREE, 48'h8000_0000_0000, 32'hFFFF_FFFF));
    send_item(mk(OP_FREE, 48'h4000_0000_0000, '0));
    send_item(mk(OP_FREE, 48'h4000_0000_0000, 32'h0000_1001));
    send_item(mk(OP_ALLOC, '0, 32'hFFFF_F000));
    send_item(mk(OP_ALLOC, '0, 32'h0000_2000));
    send_item(mk(OP_NOP, 48'h5555_5555_5555, 32'hAAAA_AAAA));
    send_item(mk(OP_FREE, 48'h0000_0000_0001, 32'h7FFF_FFFF));
    set_area('0, '0);
    send_item(mk(OP_INIT, '0, '0));
    send_item(mk(OP_FREE, 48'h0, 32'h1000));
    send_item(mk(OP_ALLOC, '0, 32'h1000));
  endtask

  // fill every slot, overflow it, then merge into the full table
  task automatic test_table_full();
    set_area('0, 32'h1000);
    send_item(mk(OP_INIT, '0, '0));
    for (int k = 1; k < SLOTS; k++) send_item(mk(OP_FREE, 48'h10000 * k, 32'h1000));
    send_item(mk(OP_FREE, 48'h10000 * (SLOTS + 6), 32'd1));
    send_item(mk(OP_FREE, 48'h1000, 32'h1000));
    send_item(mk(OP_FREE, 48'h2000, 32'he000));
    send_item(mk(OP_FREE, 48'h10000 * (SLOTS + 6), 32'd1));
    send_item(mk(OP_ALLOC, '0, 32'h11000));
  endtask

  task automatic random_phase(input int n_items);
    int r, j;
    span_t s;
    send_item(mk(OP_INIT, rand_addr(), $urandom()));
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_item(mk(OP_ALLOC, rand_addr(), $urandom_range(0, 6 * PAGE)));
      end else if (r < 42) begin
        send_item(mk(OP_ALLOC, rand_addr(), PAGE * $urandom_range(0, 8)));
      end else if (r < 78 && granted_q.size() != 0) begin
        j = $urandom_range(0, granted_q.size() - 1);
        s = granted_q[j];
        granted_q.delete(j);
        send_item(mk(OP_FREE, s.base, s.bytes));
      end else if (r < 86) begin
        send_item(mk(OP_FREE, area_base_q + PAGE * $urandom_range(0, 300),
                     $urandom_range(0, 3 * PAGE)));
      end else if (r < 90) begin
        send_item(mk(OP_FREE, rand_addr(), $urandom()));
      end else if (r < 94) begin
        send_item(mk(OP_NOP, rand_addr(), $urandom()));
      end else if (r < 97) begin
        send_item(mk(OP_ALLOC, rand_addr(), $urandom()));
      end else begin
        send_item(mk(OP_INIT, rand_addr(), $urandom()));
      end
    end
  endtask

  task automatic test_random();
    set_area(rand_addr() & 48'hFFFF_FFFF_F000, 32'h10000);
    random_phase(400);
    set_area(48'hFFFF_FFFF_0000, 32'h40000);
    no_gaps = 1'b1;
    random_phase(400);
    no_gaps = 1'b0;
    set_area(rand_addr(), $urandom());
    random_phase(400);
    set_area(rand_addr(), PAGE * $urandom_range(1, 200) + $urandom_range(0, PAGE - 1));
    random_phase(400);
  endtask

  always @(posedge clk) begin : check_results
    ffra_out_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("result with none expected: %h", result);
      end else begin
        want = outcome_q.pop_front();
        if (result.status !== want.status || result.alloc_address !== want.alloc_address)
        begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                     want.status, result.status, want.alloc_address, result.alloc_address);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_extremes();
    test_table_full();
    test_random();
    wait_idle();
    if (outcome_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("tb_first_fit_region_allocator passed");
    end else begin
      $display("tb_first_fit_region_allocator failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_first_fit_region_allocator failed");
    $finish;
  end

endmodule
